@@ hdl/mrb_pkg.sv @@
// Shared types, codes and saturation helpers for the modal resonator bank.
package mrb_pkg;

	localparam int MODES_DEF   = 16;
	localparam int INPUTS_DEF  = 4;
	localparam int OUTPUTS_DEF = 4;

	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_SAMPLE = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;

	localparam logic [3:0] SEL_COS  = 4'd0;
	localparam logic [3:0] SEL_SINR = 4'd1;
	localparam logic [3:0] SEL_NSIN = 4'd2;
	localparam logic [3:0] SEL_FPOS = 4'd3;
	localparam logic [3:0] SEL_FVEL = 4'd4;
	localparam logic [3:0] SEL_INC  = 4'd5;
	localparam logic [3:0] SEL_OBS  = 4'd6;
	localparam logic [3:0] SEL_POS  = 4'd7;
	localparam logic [3:0] SEL_VEL  = 4'd8;

	// ring pass codes
	localparam logic [3:0] PASS_ACC = 4'd0;
	localparam logic [3:0] PASS_TP1 = 4'd1;
	localparam logic [3:0] PASS_TP2 = 4'd2;
	localparam logic [3:0] PASS_TV1 = 4'd3;
	localparam logic [3:0] PASS_TV2 = 4'd4;
	localparam logic [3:0] PASS_PX  = 4'd5;
	localparam logic [3:0] PASS_PC  = 4'd6;
	localparam logic [3:0] PASS_VX  = 4'd7;
	localparam logic [3:0] PASS_VC  = 4'd8;
	localparam logic [3:0] PASS_OBS = 4'd9;

	typedef logic signed [17:0] coef_t;
	typedef logic signed [55:0] osum_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [3:0]         table_select;
		logic [5:0]         row;
		logic [5:0]         column;
		logic signed [31:0] write_value;
		logic signed [15:0] sample;
		logic               last_element;
	} in_word_t;

	typedef struct packed {
		logic               kind;
		logic [5:0]         index;
		logic signed [31:0] result_value;
		logic               last;
	} out_word_t;

	typedef struct packed {
		logic signed [31:0] pos;
		logic signed [31:0] vel;
		logic signed [47:0] acc;
		logic signed [51:0] tp;
		logic signed [51:0] tv;
		coef_t              c_cos;
		coef_t              c_sinr;
		coef_t              c_nsin;
		coef_t              c_fpos;
		coef_t              c_fvel;
	} mode_t;

	typedef struct packed {
		logic [3:0]         sel;
		logic [5:0]         addr;
		logic signed [31:0] value;
	} wr_t;

	function automatic coef_t sat_coef(input logic signed [31:0] v);
		coef_t r;
		if (v > 32'sd131071) r = 18'sh1ffff;
		else if (v < -32'sd131072) r = 18'sh20000;
		else r = v[17:0];
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647) r = 32'sh7fffffff;
		else if (x < -64'sd2147483648) r = 32'sh80000000;
		else r = x[31:0];
		return r;
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [48:0] x);
		logic signed [47:0] r;
		if (x[48] != x[47]) r = x[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		else r = x[47:0];
		return r;
	endfunction

endpackage

@@ hdl/mrb_if.sv @@
// Valid/ready channel interfaces for command words and result words.
interface mrb_in_if import mrb_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface mrb_out_if import mrb_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ hdl/modal_resonator_bank.sv @@
// Top level of the modal resonator bank: cell ring, head unit and sequencer.
//
// Usage: command words enter on req, result words leave on rsp (valid/ready,
// a word moves at a clock edge with both high).
//  - write (cmd 0): loads one table, matrix or state entry, no result word.
//  - read (cmd 2): one result word (kind 1) the cycle after acceptance.
//  - sample (cmd 1): one ring pass when the element counter is below INPUTS,
//    none otherwise. A word marked last_element then runs eight more passes
//    for the state update, and one pass plus a hand-off through the emit
//    state per observation output, giving OUTPUTS result words (kind 0) in
//    index order.
// Modes are handled in turn at the ring head: all modes pass a single shared
// multiplier there, one mode per cycle while a pass runs.
// Only one command word is in flight; req.ready is low while a pass runs or
// a result word waits. A stalled receiver holds the result word and the
// ring stands still until it is taken.
// Reset clears position, velocity, force accumulators, coefficients and the
// element counter; matrix entries are undefined until written.
module modal_resonator_bank import mrb_pkg::*; #(
	parameter int MODES   = MODES_DEF,
	parameter int INPUTS  = INPUTS_DEF,
	parameter int OUTPUTS = OUTPUTS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	mrb_in_if.sink      req,
	mrb_out_if.source   rsp
);

	localparam int SW = (MODES > 1) ? $clog2(MODES) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]         state_q;
	logic [3:0]         pass_q;
	logic [SW-1:0]      shift_q;
	logic [5:0]         cnt_q;
	logic [5:0]         cidx_q;
	logic [5:0]         o_q;
	logic               last_q;
	logic signed [15:0] sample_q;
	osum_t              sum_q;
	out_word_t          out_q;
	logic               ovalid_q;

	mode_t cq    [MODES];
	coef_t cinc  [MODES][INPUTS];
	coef_t cobs  [MODES][OUTPUTS];
	logic  wr_en [MODES];

	mode_t alu_st;
	osum_t alu_sum;
	coef_t inc_h;
	coef_t obs_h;
	wr_t   wr;
	logic  accept;
	logic  shift;
	logic signed [31:0] rd_val;

	assign req.ready = (state_q == ST_IDLE) && !ovalid_q;
	assign accept    = req.valid && req.ready;
	assign shift     = (state_q == ST_RUN);
	assign rsp.valid = ovalid_q;
	assign rsp.data  = out_q;

	// write port: matrix tables address by column, observation by output row
	assign wr.sel   = req.data.table_select;
	assign wr.addr  = (req.data.table_select == SEL_OBS) ? req.data.row : req.data.column;
	assign wr.value = req.data.write_value;

	always_comb begin
		for (int i = 0; i < MODES; i++) begin
			wr_en[i] = 1'b0;
			if (accept && req.data.cmd == CMD_WRITE) begin
				if (req.data.table_select == SEL_OBS)
					wr_en[i] = (req.data.column == 6'(i)) &&
					           ({1'b0, req.data.row} < 7'(OUTPUTS));
				else if (req.data.table_select == SEL_INC)
					wr_en[i] = (req.data.row == 6'(i)) &&
					           ({1'b0, req.data.column} < 7'(INPUTS));
				else
					wr_en[i] = (req.data.row == 6'(i));
			end
		end
	end

	// readback: pick the addressed cell while the ring is at rest
	always_comb begin
		rd_val = '0;
		for (int i = 0; i < MODES; i++) begin
			if (req.data.row == 6'(i)) begin
				if (req.data.table_select == SEL_POS) rd_val = cq[i].pos;
				else if (req.data.table_select == SEL_VEL) rd_val = cq[i].vel;
			end
		end
	end

	// head operands from the cell leaving the ring
	always_comb begin
		inc_h = cinc[0][0];
		obs_h = cobs[0][0];
		for (int j = 0; j < INPUTS; j++)
			if (cidx_q == 6'(j)) inc_h = cinc[0][j];
		for (int j = 0; j < OUTPUTS; j++)
			if (o_q == 6'(j)) obs_h = cobs[0][j];
	end

	mrb_alu u_alu (
		.pass    (pass_q),
		.st      (cq[0]),
		.inc     (inc_h),
		.obs     (obs_h),
		.sample  (sample_q),
		.sum     (sum_q),
		.st_out  (alu_st),
		.sum_out (alu_sum)
	);

	for (genvar i = 0; i < MODES; i++) begin : g_cell
		if (i == MODES - 1) begin : g_tail
			mrb_cell #(.INPUTS(INPUTS), .OUTPUTS(OUTPUTS)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.d_in   (alu_st),
				.inc_in (cinc[0]),
				.obs_in (cobs[0]),
				.wr_en  (wr_en[i]),
				.wr     (wr),
				.q      (cq[i]),
				.inc_q  (cinc[i]),
				.obs_q  (cobs[i])
			);
		end else begin : g_mid
			mrb_cell #(.INPUTS(INPUTS), .OUTPUTS(OUTPUTS)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.d_in   (cq[i+1]),
				.inc_in (cinc[i+1]),
				.obs_in (cobs[i+1]),
				.wr_en  (wr_en[i]),
				.wr     (wr),
				.q      (cq[i]),
				.inc_q  (cinc[i]),
				.obs_q  (cobs[i])
			);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && req.data.cmd == CMD_SAMPLE) begin
			sample_q <= req.data.sample;
			cidx_q   <= cnt_q;
		end
		if (state_q == ST_RUN && pass_q == PASS_OBS)
			sum_q <= alu_sum;
		else if (state_q != ST_RUN)
			sum_q <= '0;
		if (accept && req.data.cmd == CMD_READ) begin
			out_q.kind         <= 1'b1;
			out_q.index        <= req.data.row;
			out_q.result_value <= rd_val;
			out_q.last         <= 1'b1;
		end else if (state_q == ST_RUN && pass_q == PASS_OBS &&
		             shift_q == SW'(MODES - 1)) begin
			out_q.kind         <= 1'b0;
			out_q.index        <= o_q;
			out_q.result_value <= sat32(64'(alu_sum >>> 16));
			out_q.last         <= (o_q == 6'(OUTPUTS - 1));
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pass_q   <= PASS_ACC;
			shift_q  <= '0;
			cnt_q    <= '0;
			o_q      <= '0;
			last_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			// drop the result word once taken; a new one is only raised while none waits
			if (ovalid_q && rsp.ready) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.data.cmd)
							CMD_SAMPLE: begin
								last_q  <= req.data.last_element;
								cnt_q   <= cnt_q + 6'd1;
								shift_q <= '0;
								if ({1'b0, cnt_q} < 7'(INPUTS)) begin
									pass_q  <= PASS_ACC;
									state_q <= ST_RUN;
								end else if (req.data.last_element) begin
									pass_q  <= PASS_TP1;
									state_q <= ST_RUN;
								end
							end
							CMD_READ: ovalid_q <= 1'b1;
							default: ;
						endcase
					end
				end
				ST_RUN: begin
					if (shift_q == SW'(MODES - 1)) begin
						shift_q <= '0;
						case (pass_q)
							PASS_ACC: begin
								if (last_q) pass_q <= PASS_TP1;
								else state_q <= ST_IDLE;
							end
							PASS_TP1: pass_q <= PASS_TP2;
							PASS_TP2: pass_q <= PASS_TV1;
							PASS_TV1: pass_q <= PASS_TV2;
							PASS_TV2: pass_q <= PASS_PX;
							PASS_PX:  pass_q <= PASS_PC;
							PASS_PC:  pass_q <= PASS_VX;
							PASS_VX:  pass_q <= PASS_VC;
							PASS_VC: begin
								pass_q <= PASS_OBS;
								o_q    <= '0;
								cnt_q  <= '0;
							end
							PASS_OBS: begin
								ovalid_q <= 1'b1;
								state_q  <= ST_EMIT;
							end
							default: state_q <= ST_IDLE;
						endcase
					end else begin
						shift_q <= shift_q + 1'b1;
					end
				end
				ST_EMIT: begin
					// hold until the result word is taken
					if (!ovalid_q) begin
						if (o_q == 6'(OUTPUTS - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							o_q     <= o_q + 6'd1;
							state_q <= ST_RUN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ hdl/mrb_cell.sv @@
// One mode cell of the ring: state, coefficients, incident row, observation column.
module mrb_cell import mrb_pkg::*; #(
	parameter int INPUTS  = INPUTS_DEF,
	parameter int OUTPUTS = OUTPUTS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift,
	input  mode_t d_in,
	input  coef_t inc_in [INPUTS],
	input  coef_t obs_in [OUTPUTS],
	input  logic  wr_en,
	input  wr_t   wr,
	output mode_t q,
	output coef_t inc_q [INPUTS],
	output coef_t obs_q [OUTPUTS]
);

	mode_t st_q;
	coef_t wc;

	assign q  = st_q;
	assign wc = sat_coef(wr.value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (shift) begin
			st_q <= d_in;
		end else if (wr_en) begin
			case (wr.sel)
				SEL_COS:  st_q.c_cos  <= wc;
				SEL_SINR: st_q.c_sinr <= wc;
				SEL_NSIN: st_q.c_nsin <= wc;
				SEL_FPOS: st_q.c_fpos <= wc;
				SEL_FVEL: st_q.c_fvel <= wc;
				SEL_POS:  st_q.pos    <= wr.value;
				SEL_VEL:  st_q.vel    <= wr.value;
				default: ;
			endcase
		end
	end

	// matrix entries travel with the cell; no reset
	always_ff @(posedge clk) begin
		if (shift) begin
			inc_q <= inc_in;
			obs_q <= obs_in;
		end else if (wr_en) begin
			for (int j = 0; j < INPUTS; j++)
				if (wr.sel == SEL_INC && wr.addr == 6'(j)) inc_q[j] <= wc;
			for (int j = 0; j < OUTPUTS; j++)
				if (wr.sel == SEL_OBS && wr.addr == 6'(j)) obs_q[j] <= wc;
		end
	end

endmodule

@@ hdl/mrb_alu.sv @@
// Shared head unit: one multiply and add applied to the cell leaving the ring.
module mrb_alu import mrb_pkg::*; (
	input  logic [3:0]         pass,
	input  mode_t              st,
	input  coef_t              inc,
	input  coef_t              obs,
	input  logic signed [15:0] sample,
	input  osum_t              sum,
	output mode_t              st_out,
	output osum_t              sum_out
);

	coef_t              ca;
	logic signed [32:0] cb;
	logic signed [50:0] prod;
	logic signed [32:0] lo;
	logic signed [32:0] hi;

	assign lo   = $signed({17'd0, st.acc[15:0]});
	assign hi   = 33'($signed(st.acc[47:16]));
	assign prod = ca * cb;

	always_comb begin
		ca = st.c_cos;
		cb = 33'(st.pos);
		case (pass)
			PASS_ACC: begin ca = inc;       cb = 33'(sample); end
			PASS_TP1: begin ca = st.c_cos;  cb = 33'(st.pos); end
			PASS_TP2: begin ca = st.c_sinr; cb = 33'(st.vel); end
			PASS_TV1: begin ca = st.c_nsin; cb = 33'(st.pos); end
			PASS_TV2: begin ca = st.c_cos;  cb = 33'(st.vel); end
			PASS_PX:  begin ca = st.c_fpos; cb = lo; end
			PASS_PC:  begin ca = st.c_fpos; cb = hi; end
			PASS_VX:  begin ca = st.c_fvel; cb = lo; end
			PASS_VC:  begin ca = st.c_fvel; cb = hi; end
			PASS_OBS: begin ca = obs;       cb = 33'(st.pos); end
			default: ;
		endcase
	end

	always_comb begin
		st_out  = st;
		sum_out = sum;
		case (pass)
			PASS_ACC: st_out.acc = sat48(49'(st.acc) + 49'(prod));
			PASS_TP1: st_out.tp  = 52'(prod);
			PASS_TP2: st_out.tp  = st.tp + 52'(prod);
			PASS_TV1: st_out.tv  = 52'(prod);
			PASS_TV2: st_out.tv  = st.tv + 52'(prod);
			PASS_PX:  st_out.tp  = st.tp + 52'(prod);
			PASS_PC:  st_out.pos = sat32(64'(prod) + 64'(st.tp >>> 16));
			PASS_VX:  st_out.tv  = st.tv + 52'(prod);
			PASS_VC: begin
				st_out.vel = sat32(64'(prod) + 64'(st.tv >>> 16));
				st_out.acc = '0;
			end
			PASS_OBS: sum_out = sum + 56'(prod);
			default: ;
		endcase
	end

endmodule

@@ tb/mrb_checker.sv @@
// Result checker: predicts the bank's result words and compares them with the rsp channel.
module mrb_checker import mrb_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	mrb_in_if    req,
	mrb_out_if   rsp,
	output int   mismatches,
	output int   outstanding
);

	localparam int MODES   = MODES_DEF;
	localparam int INPUTS  = INPUTS_DEF;
	localparam int OUTPUTS = OUTPUTS_DEF;
	localparam longint COEF_HI = 131071;
	localparam longint COEF_LO = -131072;
	localparam longint W32_HI  = 64'sd2147483647;
	localparam longint W32_LO  = -64'sd2147483648;
	localparam longint ACC_HI  = 64'sd140737488355327;
	localparam longint ACC_LO  = -64'sd140737488355328;

	longint mode_pos [MODES];
	longint mode_vel [MODES];
	longint force_acc [MODES];
	longint cos_c [MODES];
	longint sinr_c [MODES];
	longint nsin_c [MODES];
	longint fpos_c [MODES];
	longint fvel_c [MODES];
	longint incident [MODES*INPUTS];
	longint observe [OUTPUTS*MODES];
	int     element_count;
	out_word_t results_due [$];

	function automatic longint clip(longint x, longint lo, longint hi);
		return (x > hi) ? hi : (x < lo) ? lo : x;
	endfunction

	// (a + f * acc) / 2^16 rounded down and clipped to 32 bits, without overflowing 64 bits
	function automatic longint rotate_force(longint a, longint f, longint acc);
		longint hi;
		longint lo;
		hi = acc >>> 16;
		lo = acc - hi * 65536;
		return clip(f * hi + ((a + f * lo) >>> 16), W32_LO, W32_HI);
	endfunction

	task automatic load_entry(in_word_t w);
		longint c;
		bit     mode_row;
		int     r;
		int     col;
		c = clip(longint'(w.write_value), COEF_LO, COEF_HI);
		r = int'(w.row);
		col = int'(w.column);
		mode_row = r < MODES;
		case (w.table_select)
			SEL_COS:  if (mode_row) cos_c[r] = c;
			SEL_SINR: if (mode_row) sinr_c[r] = c;
			SEL_NSIN: if (mode_row) nsin_c[r] = c;
			SEL_FPOS: if (mode_row) fpos_c[r] = c;
			SEL_FVEL: if (mode_row) fvel_c[r] = c;
			SEL_INC:  if (mode_row && col < INPUTS) incident[r*INPUTS + col] = c;
			SEL_OBS:  if (r < OUTPUTS && col < MODES) observe[r*MODES + col] = c;
			SEL_POS:  if (mode_row) mode_pos[r] = w.write_value;
			SEL_VEL:  if (mode_row) mode_vel[r] = w.write_value;
			default: ;
		endcase
	endtask

	task automatic take_element(in_word_t w);
		longint np [MODES];
		longint nv [MODES];
		longint sum;
		out_word_t r;
		if (element_count < INPUTS) begin
			for (int m = 0; m < MODES; m++)
				force_acc[m] = clip(force_acc[m] + incident[m*INPUTS + element_count]
					* longint'(w.sample), ACC_LO, ACC_HI);
		end
		element_count = (element_count + 1) & 63;
		if (w.last_element) begin
			for (int m = 0; m < MODES; m++) begin
				np[m] = rotate_force(cos_c[m] * mode_pos[m] + sinr_c[m] * mode_vel[m],
					fpos_c[m], force_acc[m]);
				nv[m] = rotate_force(nsin_c[m] * mode_pos[m] + cos_c[m] * mode_vel[m],
					fvel_c[m], force_acc[m]);
			end
			for (int m = 0; m < MODES; m++) begin
				mode_pos[m] = np[m];
				mode_vel[m] = nv[m];
				force_acc[m] = 0;
			end
			element_count = 0;
			for (int o = 0; o < OUTPUTS; o++) begin
				sum = 0;
				for (int m = 0; m < MODES; m++)
					sum += observe[o*MODES + m] * mode_pos[m];
				r.kind = 1'b0;
				r.index = o[5:0];
				r.result_value = 32'(clip(sum >>> 16, W32_LO, W32_HI));
				r.last = (o == OUTPUTS - 1);
				results_due.push_back(r);
			end
		end
	endtask

	task automatic read_back(in_word_t w);
		out_word_t r;
		longint v;
		int     rw;
		v = 0;
		rw = int'(w.row);
		if (rw < MODES) begin
			if (w.table_select == SEL_POS) v = mode_pos[rw];
			else if (w.table_select == SEL_VEL) v = mode_vel[rw];
		end
		r.kind = 1'b1;
		r.index = w.row;
		r.result_value = 32'(v);
		r.last = 1'b1;
		results_due.push_back(r);
	endtask

	task automatic check_word(out_word_t got);
		out_word_t want;
		if (results_due.size() == 0) begin
			$error("unexpected result word kind %0d index %0d value %0d",
				got.kind, got.index, got.result_value);
			mismatches++;
		end else begin
			want = results_due.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind expected %0d actual %0d", want.kind, got.kind);
				mismatches++;
			end
			if (got.index !== want.index) begin
				$error("index expected %0d actual %0d", want.index, got.index);
				mismatches++;
			end
			if (got.result_value !== want.result_value) begin
				$error("result_value expected %0d actual %0d",
					want.result_value, got.result_value);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$error("last expected %0d actual %0d", want.last, got.last);
				mismatches++;
			end
		end
	endtask

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < MODES; m++) begin
				mode_pos[m] = 0;
				mode_vel[m] = 0;
				force_acc[m] = 0;
			end
			element_count = 0;
			results_due.delete();
		end else begin
			if (rsp.valid && rsp.ready)
				check_word(rsp.data);
			if (req.valid && req.ready) begin
				case (req.data.cmd)
					CMD_WRITE:  load_entry(req.data);
					CMD_SAMPLE: take_element(req.data);
					CMD_READ:   read_back(req.data);
					default: ;
				endcase
			end
		end
		outstanding = results_due.size();
	end

endmodule

@@ tb/modal_resonator_bank_test.sv @@
// Testbench top: stimulus, idling, watchdog and verdict for the modal resonator bank.
module modal_resonator_bank_test;
	import mrb_pkg::*;

	localparam int MODES   = MODES_DEF;
	localparam int INPUTS  = INPUTS_DEF;
	localparam int OUTPUTS = OUTPUTS_DEF;
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int TOTAL_WORDS  = 370;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 300;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   cycle_count;
	int   words_sent;
	bit   steady_source;

	mrb_in_if  req_if ();
	mrb_out_if rsp_if ();

	modal_resonator_bank u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	mrb_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_if),
		.rsp         (rsp_if),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result side: stall on about 16 percent of cycles, except for a calm
	// window in the middle of the run where every word is taken at once.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			cycle_count <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (cycle_count > 2000 && cycle_count < 3500) rsp_if.ready <= 1'b1;
			else rsp_if.ready <= ($urandom_range(0, 99) >= 16);
		end
	end

	// Watchdog: end the run if no word moves on either channel for too long.
	// A full step end runs the update passes and one pass per output over all
	// modes, so the limit leaves plenty of room for receiver stalls on top.
	int quiet_cycles;
	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic in_word_t make_word(logic [1:0] cmd, logic [3:0] sel, logic [5:0] row,
			logic [5:0] column, logic signed [31:0] value, logic signed [15:0] smp,
			logic last_el);
		in_word_t w;
		w.cmd = cmd;
		w.table_select = sel;
		w.row = row;
		w.column = column;
		w.write_value = value;
		w.sample = smp;
		w.last_element = last_el;
		return w;
	endfunction

	// Mostly moderate coefficients so the modes ring rather than rail, with
	// the occasional full-range value that the table has to saturate.
	function automatic logic signed [31:0] coef_value();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'sd131071 : -32'sd131072;
			default: return $signed($urandom_range(0, 131072)) - 32'sd65536;
		endcase
	endfunction

	function automatic logic signed [15:0] sample_value();
		case ($urandom_range(0, 7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Present one word and hold it until the block takes it. Idle gaps go in
	// front of the word; valid is never dropped between back-to-back words.
	task automatic send(in_word_t w);
		while (!steady_source && $urandom_range(0, 99) < 16) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= w;
		do @(posedge clk); while (!req_if.ready);
		words_sent++;
	endtask

	// Stream one time step: n elements, the final one marked last.
	task automatic run_step(int n);
		for (int e = 0; e < n; e++)
			send(make_word(CMD_SAMPLE, 4'($urandom), 6'($urandom), 6'($urandom), $urandom,
				sample_value(), e == n - 1));
	endtask

	task automatic write_entry(logic [3:0] sel, int row, int column, logic signed [31:0] v);
		send(make_word(CMD_WRITE, sel, row[5:0], column[5:0], v, 16'($urandom),
			1'($urandom)));
	endtask

	task automatic read_entry(logic [3:0] sel, int row);
		send(make_word(CMD_READ, sel, row[5:0], 6'($urandom), $urandom, 16'($urandom),
			1'($urandom)));
	endtask

	task automatic random_item();
		int pick;
		logic [3:0] sel;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			// Well-formed step, sometimes short or with extra elements.
			case ($urandom_range(0, 5))
				0: run_step($urandom_range(1, INPUTS - 1));
				1: run_step($urandom_range(INPUTS + 1, INPUTS + 3));
				default: run_step(INPUTS);
			endcase
		end else if (pick < 70) begin
			sel = 4'($urandom_range(SEL_COS, SEL_VEL));
			case (sel)
				SEL_INC: write_entry(sel, $urandom_range(0, MODES - 1),
					$urandom_range(0, INPUTS - 1), coef_value());
				SEL_OBS: write_entry(sel, $urandom_range(0, OUTPUTS - 1),
					$urandom_range(0, MODES - 1), coef_value());
				SEL_POS, SEL_VEL: write_entry(sel, $urandom_range(0, MODES - 1), $urandom,
					$urandom);
				default: write_entry(sel, $urandom_range(0, MODES - 1), $urandom,
					coef_value());
			endcase
		end else if (pick < 77) begin
			// Out-of-range address or table: must be dropped.
			write_entry(4'($urandom), $urandom_range(MODES, 63), $urandom_range(MODES, 63),
				$urandom);
		end else if (pick < 94) begin
			read_entry($urandom_range(0, 3) == 0 ? 4'($urandom) : ($urandom_range(0, 1) ?
				SEL_POS : SEL_VEL), $urandom_range(0, 5) == 0 ? $urandom :
				$urandom_range(0, MODES - 1));
		end else begin
			send(make_word(CMD_SPARE, 4'($urandom), 6'($urandom), 6'($urandom), $urandom,
				16'($urandom), 1'($urandom)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		steady_source = 1'b0;
		words_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load every coefficient entry before any step can read it.
		for (int m = 0; m < MODES; m++) begin
			for (int s = SEL_COS; s <= SEL_FVEL; s++)
				write_entry(s[3:0], m, $urandom, coef_value());
			for (int i = 0; i < INPUTS; i++)
				write_entry(SEL_INC, m, i, coef_value());
		end
		for (int o = 0; o < OUTPUTS; o++)
			for (int m = 0; m < MODES; m++)
				write_entry(SEL_OBS, o, m, coef_value());

		// Directed: saturating writes, state extremes, reads of every kind,
		// out-of-range writes, the spare command, extra and wrapping elements.
		write_entry(SEL_COS, 0, 0, 32'sh7fffffff);
		write_entry(SEL_SINR, MODES - 1, 63, 32'sh80000000);
		write_entry(SEL_POS, 0, 0, 32'sh7fffffff);
		write_entry(SEL_VEL, MODES - 1, 0, 32'sh80000000);
		write_entry(4'd15, 0, 0, 32'sh12345678);
		write_entry(SEL_INC, 0, INPUTS, 32'sh1000);
		write_entry(SEL_OBS, OUTPUTS, 0, 32'sh1000);
		write_entry(SEL_POS, 63, 0, 32'sh1000);
		read_entry(SEL_POS, 0);
		read_entry(SEL_VEL, MODES - 1);
		read_entry(SEL_COS, 3);
		read_entry(SEL_POS, 63);
		send(make_word(CMD_SPARE, 4'hf, 6'h3f, 6'h3f, 32'sh7fffffff, 16'sh7fff, 1'b1));
		run_step(INPUTS);
		run_step(1);
		run_step(INPUTS + 2);
		run_step(66);
		read_entry(SEL_POS, 5);
		read_entry(SEL_VEL, 5);

		// Random phase up to the word budget, with a stretch where the source
		// never idles.
		while (words_sent < TOTAL_WORDS) begin
			steady_source = (words_sent > 310 && words_sent < 350);
			random_item();
		end
		steady_source = 1'b0;
		req_if.valid <= 1'b0;

		// Drain: wait for every expected word, then allow the ring to settle.
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

@@ modal_resonator_bank.f @@
hdl/mrb_pkg.sv
hdl/mrb_if.sv
hdl/mrb_cell.sv
hdl/mrb_alu.sv
hdl/modal_resonator_bank.sv
tb/mrb_checker.sv
tb/modal_resonator_bank_test.sv
